@@ hdl/kruskal_union_find_edge_engine_top_macros.svh @@
// ----------------------------------------------------------------------------
// kuf assertion macros
// shared property shapes for the edge engine checkers
// ----------------------------------------------------------------------------
`ifndef KRUSKAL_UNION_FIND_EDGE_ENGINE_TOP_MACROS_SVH
`define KRUSKAL_UNION_FIND_EDGE_ENGINE_TOP_MACROS_SVH

// same-cycle implication, clocked on clock, quiet while reset is high
`define KUF_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, quiet while reset is high
`define KUF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/kuf_pkg.sv @@
// ----------------------------------------------------------------------------
// kuf_pkg
// widths, limits and the forest entry type of the union-find edge engine
// ----------------------------------------------------------------------------
package kuf_pkg;

   localparam int MAX_NODES   = 1024;
   localparam int NODE_W      = $clog2(MAX_NODES);
   localparam int COUNT_W     = 11;
   localparam int WEIGHT_W    = 16;
   localparam int SUM_W       = 32;
   localparam int RANK_W      = 4;
   localparam int RANK_MAX    = (1 << RANK_W) - 1;

   // stream payload widths, padded to whole bytes
   localparam int REQ_BITS    = 2 * NODE_W + WEIGHT_W;
   localparam int REQ_DATA_W  = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = 1 + 2 * SUM_W;
   localparam int RSP_DATA_W  = ((RSP_BITS + 7) / 8) * 8;

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic [NODE_W-1:0] parent;
   } entry_type;

endpackage

@@ hdl/kruskal_union_find_edge_engine_top.sv @@
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_engine_top
// sequence: a bad edge goes straight to the saving subtract and result load;
//   otherwise each endpoint is walked to its root and its path compressed, then
//   the sums, root link and rank bump if the edge is taken, subtract and load
// throughput: one edge at a time; ready again the cycle after a non-last result is loaded
// reset and last edge: a clearing pass over all 1024 entries rebuilds the forest memory
// ----------------------------------------------------------------------------
module kruskal_union_find_edge_engine_top (
   input  logic                            clock,
   input  logic                            reset,
   // configuration: node count
   input  logic                            csr_wr_en,
   input  logic [kuf_pkg::COUNT_W-1:0]     csr_wr_data,
   // edge items: node_a [9:0], node_b [19:10], weight [35:20], zero pad
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [kuf_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tlast,   // last_edge
   // result items: accepted [0], tree_cost [32:1], saving [64:33], zero pad
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [kuf_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tuser,   // bad_index
   output logic                            rsp_tlast    // graph_done
);

   import kuf_pkg::*;

   // sequencer codes
   localparam logic [3:0] S_IDLE  = 4'd0;   // waiting for an edge
   localparam logic [3:0] S_WALK  = 4'd1;   // climbing parent links to the root
   localparam logic [3:0] S_COMP  = 4'd2;   // path compression, one node a cycle
   localparam logic [3:0] S_SUMW  = 4'd3;   // total weight add
   localparam logic [3:0] S_SUMT  = 4'd4;   // tree cost add, root link write
   localparam logic [3:0] S_JOIN  = 4'd5;   // rank bump of the new root
   localparam logic [3:0] S_DIFF  = 4'd6;   // saving subtract
   localparam logic [3:0] S_OUT   = 4'd7;   // load result register
   localparam logic [3:0] S_CLEAR = 4'd8;   // forest rebuild sweep

   localparam int PAD_W = RSP_DATA_W - RSP_BITS;

   // control state
   logic [3:0]          state_ff, state_in;
   logic [NODE_W-1:0]   clr_ff, clr_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                phase_ff, phase_in;      // 0 while finding node_a, 1 for node_b
   logic [SUM_W-1:0]    tree_ff, tree_in;
   logic [SUM_W-1:0]    wsum_ff, wsum_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // item and walk registers
   logic [NODE_W-1:0]   node_a_ff, node_a_in;
   logic [NODE_W-1:0]   node_b_ff, node_b_in;
   logic [WEIGHT_W-1:0] weight_ff, weight_in;
   logic                last_ff, last_in;
   logic                bad_ff, bad_in;
   logic                acc_ff, acc_in;
   logic [NODE_W-1:0]   walk_ff, walk_in;        // node whose entry is in rdata_ff
   logic [NODE_W-1:0]   start_ff, start_in;      // first node of the current find
   logic [NODE_W-1:0]   cur_ff, cur_in;          // node being compressed
   logic [NODE_W-1:0]   root_ff, root_in;
   logic [NODE_W-1:0]   ra_ff, ra_in;
   logic [NODE_W-1:0]   rb_ff, rb_in;
   logic [RANK_W-1:0]   rank_a_ff, rank_a_in;
   logic [RANK_W-1:0]   rank_b_ff, rank_b_in;
   logic [SUM_W-1:0]    saving_ff, saving_in;

   // result register payload
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_bad_ff, rsp_bad_in;
   logic                  rsp_last_ff, rsp_last_in;

   // forest memory, one write and one read port, registered read
   entry_type           mem [MAX_NODES];
   entry_type           rdata_ff;
   logic                mem_we;
   logic [NODE_W-1:0]   mem_waddr;
   entry_type           mem_wdata;
   logic [NODE_W-1:0]   mem_raddr;

   // shared add/subtract unit
   logic [SUM_W-1:0]    alu_a, alu_b;
   logic                alu_sub;
   logic [SUM_W:0]      alu_res;
   logic [SUM_W-1:0]    alu_sat;

   // item decode
   logic [COUNT_W-1:0]  limit;
   logic [NODE_W-1:0]   req_a, req_b;
   logic [SUM_W-1:0]    weight_ext;

   assign req_a      = req_tdata[NODE_W-1:0];
   assign req_b      = req_tdata[2*NODE_W-1:NODE_W];
   assign limit      = (count_ff > COUNT_W'(MAX_NODES)) ? COUNT_W'(MAX_NODES) : count_ff;
   assign weight_ext = SUM_W'(weight_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_bad_ff;
   assign rsp_tlast  = rsp_last_ff;

   // operand selection for the shared unit
   always_comb begin
      alu_a   = wsum_ff;
      alu_b   = weight_ext;
      alu_sub = 1'b0;
      case (state_ff)
         S_SUMT: begin
            alu_a = tree_ff;
         end
         S_DIFF: begin
            alu_b   = tree_ff;
            alu_sub = 1'b1;
         end
         default: begin
         end
      endcase
      alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                        : ({1'b0, alu_a} + {1'b0, alu_b});
      alu_sat = alu_res[SUM_W] ? {SUM_W{1'b1}} : alu_res[SUM_W-1:0];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      count_in     = csr_wr_en ? csr_wr_data : count_ff;
      phase_in     = phase_ff;
      tree_in      = tree_ff;
      wsum_in      = wsum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      node_a_in    = node_a_ff;
      node_b_in    = node_b_ff;
      weight_in    = weight_ff;
      last_in      = last_ff;
      bad_in       = bad_ff;
      acc_in       = acc_ff;
      walk_in      = walk_ff;
      start_in     = start_ff;
      cur_in       = cur_ff;
      root_in      = root_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      rank_a_in    = rank_a_ff;
      rank_b_in    = rank_b_ff;
      saving_in    = saving_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_waddr    = cur_ff;
      mem_wdata    = rdata_ff;
      mem_raddr    = walk_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               node_a_in = req_a;
               node_b_in = req_b;
               weight_in = req_tdata[2*NODE_W+WEIGHT_W-1:2*NODE_W];
               last_in   = req_tlast;
               acc_in    = 1'b0;
               bad_in    = ({1'b0, req_a} >= limit) || ({1'b0, req_b} >= limit);
               phase_in  = 1'b0;
               walk_in   = req_a;
               start_in  = req_a;
               mem_raddr = req_a;
               if (({1'b0, req_a} >= limit) || ({1'b0, req_b} >= limit)) begin
                  state_in = S_DIFF;    // ignored edge, totals unchanged
               end else begin
                  state_in = S_WALK;
               end
            end
         end

         S_WALK: begin
            if (rdata_ff.parent == walk_ff) begin
               // root reached
               root_in = walk_ff;
               if (!phase_ff) begin
                  ra_in     = walk_ff;
                  rank_a_in = rdata_ff.rank;
               end else begin
                  rb_in     = walk_ff;
                  rank_b_in = rdata_ff.rank;
               end
               if (start_ff != walk_ff) begin
                  cur_in    = start_ff;
                  mem_raddr = start_ff;
                  state_in  = S_COMP;
               end else if (!phase_ff) begin
                  phase_in  = 1'b1;
                  walk_in   = node_b_ff;
                  start_in  = node_b_ff;
                  mem_raddr = node_b_ff;
               end else begin
                  state_in  = S_SUMW;
               end
            end else begin
               walk_in   = rdata_ff.parent;
               mem_raddr = rdata_ff.parent;
            end
         end

         S_COMP: begin
            // point the current node straight at the root, move on to its old parent
            mem_we           = 1'b1;
            mem_waddr        = cur_ff;
            mem_wdata.rank   = rdata_ff.rank;
            mem_wdata.parent = root_ff;
            if (rdata_ff.parent == root_ff) begin
               if (!phase_ff) begin
                  phase_in  = 1'b1;
                  walk_in   = node_b_ff;
                  start_in  = node_b_ff;
                  mem_raddr = node_b_ff;
                  state_in  = S_WALK;
               end else begin
                  state_in  = S_SUMW;
               end
            end else begin
               cur_in    = rdata_ff.parent;
               mem_raddr = rdata_ff.parent;
            end
         end

         S_SUMW: begin
            wsum_in  = alu_sat;
            acc_in   = (ra_ff != rb_ff);
            state_in = (ra_ff != rb_ff) ? S_SUMT : S_DIFF;
         end

         S_SUMT: begin
            tree_in = alu_sat;
            // union by rank: the lower-ranked root goes under the other, root a on a tie
            mem_we  = 1'b1;
            if (rank_a_ff > rank_b_ff) begin
               mem_waddr        = rb_ff;
               mem_wdata.rank   = rank_b_ff;
               mem_wdata.parent = ra_ff;
            end else begin
               mem_waddr        = ra_ff;
               mem_wdata.rank   = rank_a_ff;
               mem_wdata.parent = rb_ff;
            end
            state_in = S_JOIN;
         end

         S_JOIN: begin
            // equal ranks grow the surviving root, saturating
            if ((rank_a_ff == rank_b_ff) && (rank_b_ff != RANK_W'(RANK_MAX))) begin
               mem_we           = 1'b1;
               mem_waddr        = rb_ff;
               mem_wdata.rank   = rank_b_ff + RANK_W'(1);
               mem_wdata.parent = rb_ff;
            end
            state_in = S_DIFF;
         end

         S_DIFF: begin
            saving_in = alu_res[SUM_W] ? '0 : alu_res[SUM_W-1:0];
            state_in  = S_OUT;
         end

         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{PAD_W{1'b0}}, saving_ff, tree_ff, acc_ff};
               rsp_bad_in   = bad_ff;
               rsp_last_in  = last_ff;
               if (last_ff) begin
                  tree_in  = '0;
                  wsum_in  = '0;
                  clr_in   = '0;
                  state_in = S_CLEAR;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         S_CLEAR: begin
            mem_we           = 1'b1;
            mem_waddr        = clr_ff;
            mem_wdata.rank   = '0;
            mem_wdata.parent = clr_ff;
            clr_in           = clr_ff + NODE_W'(1);
            if (clr_ff == NODE_W'(MAX_NODES - 1)) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= COUNT_W'(MAX_NODES);
         phase_ff     <= 1'b0;
         tree_ff      <= '0;
         wsum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         phase_ff     <= phase_in;
         tree_ff      <= tree_in;
         wsum_ff      <= wsum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      node_a_ff   <= node_a_in;
      node_b_ff   <= node_b_in;
      weight_ff   <= weight_in;
      last_ff     <= last_in;
      bad_ff      <= bad_in;
      acc_ff      <= acc_in;
      walk_ff     <= walk_in;
      start_ff    <= start_in;
      cur_ff      <= cur_in;
      root_ff     <= root_in;
      ra_ff       <= ra_in;
      rb_ff       <= rb_in;
      rank_a_ff   <= rank_a_in;
      rank_b_ff   <= rank_b_in;
      saving_ff   <= saving_in;
      rsp_data_ff <= rsp_data_in;
      rsp_bad_ff  <= rsp_bad_in;
      rsp_last_ff <= rsp_last_in;
   end

   // forest memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

endmodule

@@ hdl/kuf_checker.sv @@
// ----------------------------------------------------------------------------
// kuf_checker
// port-level checks of the union-find edge engine, bound to the top level
// ----------------------------------------------------------------------------
`include "kruskal_union_find_edge_engine_top_macros.svh"

module kuf_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [kuf_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tuser
);

   import kuf_pkg::*;

   // a waiting result holds still
   `KUF_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result item changed while stalled")

   // an ignored edge never enters the tree
   `KUF_ASSERT_NOW(a_bad_not_taken, rsp_tvalid && rsp_tuser, !rsp_tdata[0], "bad edge reported as taken")

   // one edge at a time: ready drops right after an accept
   `KUF_ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready, !req_tready, "second item accepted while busy")

endmodule

bind kruskal_union_find_edge_engine_top kuf_checker u_kuf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
